// File: hdl/esd_pkg.sv
// ============================================================================
// esd_pkg
// Shared widths, reciprocal constants and the month-start table for the
// epoch seconds to calendar date pipeline.
// ============================================================================
package esd_pkg;

   localparam int SECS_W  = 31;
   localparam int DAYS_W  = 15;
   localparam int SOD_W   = 17;
   localparam int PIPE_DEPTH = 6;

   // seconds / 86400 == (seconds >> 7) / 675, reciprocal 2^34 / 675 rounded up
   localparam logic [24:0] DAY_RECIP   = 25'd25451659;
   localparam int          DAY_SHIFT   = 34;
   localparam logic [16:0] SECS_PER_DAY = 17'd86400;

   // (sod >> 4) / 225, reciprocal 2^21 / 225 rounded up
   localparam logic [13:0] HOUR_RECIP  = 14'd9321;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

   // (rem >> 2) / 15, reciprocal 2^14 / 15 rounded up
   localparam logic [10:0] MIN_RECIP   = 11'd1093;
   localparam logic [5:0]  SECS_PER_MIN = 6'd60;

   // x / 7, reciprocal 2^18 / 7 rounded up
   localparam logic [15:0] WEEK_RECIP  = 16'd37450;
   localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
   localparam logic [2:0]  WEEKDAY_AT_EPOCH = 3'd4;

   // x / 1461, reciprocal 2^26 / 1461 rounded up; days counted from 1968-01-01
   localparam logic [15:0] CYCLE_RECIP = 16'd45934;
   localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
   localparam logic [9:0]  DAYS_1968_TO_EPOCH = 10'd731;
   localparam logic [8:0]  DAYS_PLAIN_YEAR = 9'd365;
   localparam logic [8:0]  DAYS_LEAP_YEAR  = 9'd366;
   localparam logic [7:0]  YEAR_1968_SINCE_1900 = 8'd68;

   localparam int MONTHS = 12;

   function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
      logic [8:0] base;
      begin
         unique case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd365;
         endcase
         if (leap && (idx >= 4'd2)) begin
            base = base + 9'd1;
         end
         return base;
      end
   endfunction

endpackage

// File: hdl/epoch_seconds_to_date_top.sv
// ============================================================================
// epoch_seconds_to_date_top
// Converts seconds since 1970-01-01 00:00:00 UTC to the broken-down UTC date.
// ============================================================================
//
//  channel   prefix  direction  contents
//  input     req_    in         epoch_seconds (31 bits)
//  result    rsp_    out        second, minute, hour, weekday, year, yday,
//                               month, mday
//
//  Six register stages, one transfer per cycle sustained while the result is not stalled.
//  Stage depth is set by one constant multiply per stage (reciprocal divide).
//  Synchronous reset clears the stage valid bits and holds off the input;
//  payload is not reset.
//  A stalled result freezes the whole pipeline and stalls the input side.
//
module epoch_seconds_to_date_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [30:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_second_of_minute,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [4:0]  rsp_hour_of_day,
   output logic [2:0]  rsp_day_of_week,
   output logic [7:0]  rsp_years_since_1900,
   output logic [8:0]  rsp_day_of_year,
   output logic [3:0]  rsp_month_index,
   output logic [4:0]  rsp_day_of_month
);

   logic                              advance;
   logic [esd_pkg::PIPE_DEPTH-1:0]    valid_ff;
   logic [esd_pkg::PIPE_DEPTH-1:0]    valid_in;
   logic [esd_pkg::DAYS_W-1:0]        days;
   logic [esd_pkg::SOD_W-1:0]         sec_of_day;

   assign advance   = !(valid_ff[esd_pkg::PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = reset || !advance;
   assign rsp_valid = valid_ff[esd_pkg::PIPE_DEPTH-1];

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = {valid_ff[esd_pkg::PIPE_DEPTH-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   esd_day_split u_day_split (
      .clock      (clock),
      .advance    (advance),
      .secs       (req_epoch_seconds),
      .days       (days),
      .sec_of_day (sec_of_day)
   );

   esd_time_of_day u_time_of_day (
      .clock            (clock),
      .advance          (advance),
      .sec_of_day       (sec_of_day),
      .second_of_minute (rsp_second_of_minute),
      .minute_of_hour   (rsp_minute_of_hour),
      .hour_of_day      (rsp_hour_of_day)
   );

   esd_calendar u_calendar (
      .clock            (clock),
      .advance          (advance),
      .days             (days),
      .day_of_week      (rsp_day_of_week),
      .years_since_1900 (rsp_years_since_1900),
      .day_of_year      (rsp_day_of_year),
      .month_index      (rsp_month_index),
      .day_of_month     (rsp_day_of_month)
   );

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(valid_ff))
      else $error("valid bits moved during stall");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour_of_day <= 5'd23 && rsp_minute_of_hour <= 6'd59
                     && rsp_second_of_minute <= 6'd59))
      else $error("time of day out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month_index <= 4'd11 && rsp_day_of_month != 5'd0
                     && rsp_day_of_week <= 3'd6 && rsp_day_of_year <= 9'd365))
      else $error("calendar date out of range");

endmodule

// File: hdl/esd_day_split.sv
// ============================================================================
// esd_day_split
// Stages 1-2: splits epoch seconds into whole days and seconds of the day.
// ============================================================================
module esd_day_split (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [esd_pkg::SECS_W-1:0]   secs,
   output logic [esd_pkg::DAYS_W-1:0]   days,
   output logic [esd_pkg::SOD_W-1:0]    sec_of_day
);

   logic [esd_pkg::SECS_W-1:0] secs1_ff;
   logic [48:0]                prod1_ff;
   logic [48:0]                prod1_in;
   logic [esd_pkg::DAYS_W-1:0] days2_ff;
   logic [esd_pkg::DAYS_W-1:0] days2_in;
   logic [esd_pkg::SOD_W-1:0]  sod2_ff;
   logic [esd_pkg::SOD_W-1:0]  sod2_in;
   logic [esd_pkg::SECS_W-1:0] sod_full;

   assign prod1_in = 49'(secs[30:7]) * 49'(esd_pkg::DAY_RECIP);

   always_comb begin
      days2_in = prod1_ff[48:esd_pkg::DAY_SHIFT];
      sod_full = secs1_ff - 31'(days2_in) * 31'(esd_pkg::SECS_PER_DAY);
      sod2_in  = sod_full[esd_pkg::SOD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         secs1_ff <= secs;
         prod1_ff <= prod1_in;
         days2_ff <= days2_in;
         sod2_ff  <= sod2_in;
      end
   end

   assign days       = days2_ff;
   assign sec_of_day = sod2_ff;

endmodule

// File: hdl/esd_time_of_day.sv
// ============================================================================
// esd_time_of_day
// Stages 3-6: hours, minutes and seconds from the second of the day.
// ============================================================================
module esd_time_of_day (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [esd_pkg::SOD_W-1:0]   sec_of_day,
   output logic [5:0]                  second_of_minute,
   output logic [5:0]                  minute_of_hour,
   output logic [4:0]                  hour_of_day
);

   logic [26:0]               prod_h3_ff;
   logic [26:0]               prod_h3_in;
   logic [esd_pkg::SOD_W-1:0] sod3_ff;
   logic [4:0]                hour4_ff;
   logic [4:0]                hour4_in;
   logic [11:0]               remh4_ff;
   logic [11:0]               remh4_in;
   logic [esd_pkg::SOD_W-1:0] remh_full;
   logic [4:0]                hour5_ff;
   logic [11:0]               remh5_ff;
   logic [20:0]               prod_m5_ff;
   logic [20:0]               prod_m5_in;
   logic [5:0]                min6_in;
   logic [11:0]               sec_full;
   logic [5:0]                sec6_in;
   logic [5:0]                sec6_ff;
   logic [5:0]                min6_ff;
   logic [4:0]                hour6_ff;

   assign prod_h3_in = 27'(sec_of_day[16:4]) * 27'(esd_pkg::HOUR_RECIP);

   always_comb begin
      hour4_in  = prod_h3_ff[25:21];
      remh_full = sod3_ff - 17'(hour4_in) * 17'(esd_pkg::SECS_PER_HOUR);
      remh4_in  = remh_full[11:0];
   end

   assign prod_m5_in = 21'(remh4_ff[11:2]) * 21'(esd_pkg::MIN_RECIP);

   always_comb begin
      min6_in  = prod_m5_ff[19:14];
      sec_full = remh5_ff - 12'(min6_in) * 12'(esd_pkg::SECS_PER_MIN);
      sec6_in  = sec_full[5:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_h3_ff <= prod_h3_in;
         sod3_ff    <= sec_of_day;
         hour4_ff   <= hour4_in;
         remh4_ff   <= remh4_in;
         hour5_ff   <= hour4_ff;
         remh5_ff   <= remh4_ff;
         prod_m5_ff <= prod_m5_in;
         hour6_ff   <= hour5_ff;
         min6_ff    <= min6_in;
         sec6_ff    <= sec6_in;
      end
   end

   assign second_of_minute = sec6_ff;
   assign minute_of_hour   = min6_ff;
   assign hour_of_day      = hour6_ff;

endmodule

// File: hdl/esd_calendar.sv
// ============================================================================
// esd_calendar
// Stages 3-6: weekday, year, day of year, month and day of month from the
// day count. Years are placed in four-year cycles starting 1968-01-01.
// ============================================================================
module esd_calendar (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [esd_pkg::DAYS_W-1:0]  days,
   output logic [2:0]                  day_of_week,
   output logic [7:0]                  years_since_1900,
   output logic [8:0]                  day_of_year,
   output logic [3:0]                  month_index,
   output logic [4:0]                  day_of_month
);

   // stage 3
   logic [esd_pkg::DAYS_W-1:0] wdv_in;
   logic [esd_pkg::DAYS_W-1:0] wdv3_ff;
   logic [30:0]                wdp3_in;
   logic [30:0]                wdp3_ff;
   logic [esd_pkg::DAYS_W-1:0] dd_in;
   logic [esd_pkg::DAYS_W-1:0] dd3_ff;
   logic [30:0]                cp3_in;
   logic [30:0]                cp3_ff;
   // stage 4
   logic [12:0]                wq;
   logic [esd_pkg::DAYS_W-1:0] wd_full;
   logic [2:0]                 wd4_in;
   logic [2:0]                 wd4_ff;
   logic [4:0]                 cycle4_in;
   logic [4:0]                 cycle4_ff;
   logic [esd_pkg::DAYS_W-1:0] r_full;
   logic [10:0]                r4_in;
   logic [10:0]                r4_ff;
   // stage 5
   logic [10:0]                t;
   logic [1:0]                 yi;
   logic [10:0]                doy_full;
   logic [8:0]                 doy5_in;
   logic [8:0]                 doy5_ff;
   logic                       leap5_in;
   logic                       leap5_ff;
   logic [7:0]                 year5_in;
   logic [7:0]                 year5_ff;
   logic [2:0]                 wd5_ff;
   // stage 6
   logic [3:0]                 month6_in;
   logic [3:0]                 month6_ff;
   logic [8:0]                 dom_full;
   logic [4:0]                 dom6_in;
   logic [4:0]                 dom6_ff;
   logic [2:0]                 wd6_ff;
   logic [7:0]                 year6_ff;
   logic [8:0]                 doy6_ff;

   always_comb begin
      wdv_in  = days + 15'(esd_pkg::WEEKDAY_AT_EPOCH);
      wdp3_in = 31'(wdv_in) * 31'(esd_pkg::WEEK_RECIP);
      dd_in   = days + 15'(esd_pkg::DAYS_1968_TO_EPOCH);
      cp3_in  = 31'(dd_in) * 31'(esd_pkg::CYCLE_RECIP);
   end

   always_comb begin
      wq        = wdp3_ff[30:18];
      wd_full   = wdv3_ff - 15'(wq) * 15'(esd_pkg::DAYS_PER_WEEK);
      wd4_in    = wd_full[2:0];
      cycle4_in = cp3_ff[30:26];
      r_full    = dd3_ff - 15'(cycle4_in) * 15'(esd_pkg::DAYS_PER_CYCLE);
      r4_in     = r_full[10:0];
   end

   // first year of each cycle is the leap year
   always_comb begin
      t = r4_ff - 11'd1;
      if (r4_ff < 11'(esd_pkg::DAYS_LEAP_YEAR)) begin
         yi       = 2'd0;
         leap5_in = 1'b1;
         doy_full = r4_ff;
      end else begin
         leap5_in = 1'b0;
         priority if (t >= 11'(3 * 365)) begin
            yi = 2'd3;
         end else if (t >= 11'(2 * 365)) begin
            yi = 2'd2;
         end else begin
            yi = 2'd1;
         end
         doy_full = t - 11'(yi) * 11'(esd_pkg::DAYS_PLAIN_YEAR);
      end
      doy5_in  = doy_full[8:0];
      year5_in = esd_pkg::YEAR_1968_SINCE_1900 + 8'({cycle4_ff, 2'b00}) + 8'(yi);
   end

   always_comb begin
      month6_in = 4'd0;
      for (int i = 1; i < esd_pkg::MONTHS; i++) begin
         if (esd_pkg::month_start(leap5_ff, 4'(i)) <= doy5_ff) begin
            month6_in = month6_in + 4'd1;
         end
      end
      dom_full = doy5_ff - esd_pkg::month_start(leap5_ff, month6_in) + 9'd1;
      dom6_in  = dom_full[4:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wdv3_ff   <= wdv_in;
         wdp3_ff   <= wdp3_in;
         dd3_ff    <= dd_in;
         cp3_ff    <= cp3_in;
         wd4_ff    <= wd4_in;
         cycle4_ff <= cycle4_in;
         r4_ff     <= r4_in;
         wd5_ff    <= wd4_ff;
         doy5_ff   <= doy5_in;
         leap5_ff  <= leap5_in;
         year5_ff  <= year5_in;
         wd6_ff    <= wd5_ff;
         year6_ff  <= year5_ff;
         doy6_ff   <= doy5_ff;
         month6_ff <= month6_in;
         dom6_ff   <= dom6_in;
      end
   end

   assign day_of_week      = wd6_ff;
   assign years_since_1900 = year6_ff;
   assign day_of_year      = doy6_ff;
   assign month_index      = month6_ff;
   assign day_of_month     = dom6_ff;

endmodule

// File: test/tb_epoch_seconds_to_date_top.sv
// ============================================================================
// tb_epoch_seconds_to_date_top
// Self-checking bench for the epoch seconds to UTC date pipeline. A behavioral
// calendar walk predicts every field of each result, and a small scoreboard
// compares results in order. Directed dates cover year, month and day edges,
// then random stamps run under several idle/stall mixes and a long output
// hold.
// ============================================================================

module tb_epoch_seconds_to_date_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          FEBRUARY       = 1;
   localparam int          APRIL          = 3;
   localparam int          JUNE           = 5;
   localparam int          SEPTEMBER      = 8;
   localparam int          NOVEMBER       = 10;
   localparam int          FIRST_CAL_YEAR = 1970;
   localparam int          YEAR_BASE      = 1900;
   localparam int          EPOCH_WEEKDAY  = 4;
   localparam int unsigned DAY_SECS       = 86400;
   localparam int unsigned LAST_DAY       = 24855;
   localparam logic [30:0] SECS_MAX       = 31'h7fffffff;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 12;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [2:0] weekday;
      logic [7:0] year;
      logic [8:0] yday;
      logic [3:0] month;
      logic [4:0] mday;
   } date_type;

   function automatic bit is_leap(input int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic int unsigned year_length(input int unsigned yr);
      return is_leap(yr) ? 366 : 365;
   endfunction

   function automatic int unsigned month_length(input int mon, input int unsigned yr);
      case (mon)
         FEBRUARY:                          return is_leap(yr) ? 29 : 28;
         APRIL, JUNE, SEPTEMBER, NOVEMBER:  return 30;
         default:                           return 31;
      endcase
   endfunction

   class date_scoreboard;
      date_type    pending[$];
      logic [30:0] pending_secs[$];
      int          errors = 0;

      static function date_type to_date(input logic [30:0] secs);
         int unsigned days, in_day, yr;
         int          mon;
         date_type    d;
         days      = secs / DAY_SECS;
         in_day    = secs % DAY_SECS;
         d.second  = 6'(in_day % 60);
         d.minute  = 6'((in_day / 60) % 60);
         d.hour    = 5'(in_day / 3600);
         d.weekday = 3'((days + EPOCH_WEEKDAY) % 7);
         yr = FIRST_CAL_YEAR;
         while (days >= year_length(yr)) begin
            days -= year_length(yr);
            yr++;
         end
         d.year = 8'(yr - YEAR_BASE);
         d.yday = 9'(days);
         mon = 0;
         while (days >= month_length(mon, yr)) begin
            days -= month_length(mon, yr);
            mon++;
         end
         d.month = 4'(mon);
         d.mday  = 5'(days + 1);
         return d;
      endfunction

      function void note(input logic [30:0] secs);
         pending.push_back(to_date(secs));
         pending_secs.push_back(secs);
      endfunction

      function void compare(input string name, input int unsigned exp_v,
                            input int unsigned act_v, input logic [30:0] secs);
         if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch for %0d s: expected %0d, actual %0d",
                     $time, name, secs, exp_v, act_v);
         end
      endfunction

      function void check(input date_type got);
         date_type    exp_d;
         logic [30:0] secs;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transfer: expected none, actual %p",
                     $time, got);
            return;
         end
         exp_d = pending.pop_front();
         secs  = pending_secs.pop_front();
         compare("second_of_minute", exp_d.second,  got.second,  secs);
         compare("minute_of_hour",   exp_d.minute,  got.minute,  secs);
         compare("hour_of_day",      exp_d.hour,    got.hour,    secs);
         compare("day_of_week",      exp_d.weekday, got.weekday, secs);
         compare("years_since_1900", exp_d.year,    got.year,    secs);
         compare("day_of_year",      exp_d.yday,    got.yday,    secs);
         compare("month_index",      exp_d.month,   got.month,   secs);
         compare("day_of_month",     exp_d.mday,    got.mday,    secs);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [30:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   date_type    rsp;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   date_scoreboard dates = new();

   epoch_seconds_to_date_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_second_of_minute (rsp.second),
      .rsp_minute_of_hour   (rsp.minute),
      .rsp_hour_of_day      (rsp.hour),
      .rsp_day_of_week      (rsp.weekday),
      .rsp_years_since_1900 (rsp.year),
      .rsp_day_of_year      (rsp.yday),
      .rsp_month_index      (rsp.month),
      .rsp_day_of_month     (rsp.mday)
   );

   always #10 clock = ~clock;

   // receiver: long hold when requested, else random stall
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         dates.check(rsp);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called and returns at a falling edge
   task automatic send_item(input logic [30:0] secs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (req_stall);
      dates.note(secs);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (dates.pending.size() != 0);
   endtask

   function automatic logic [30:0] pick_seconds();
      longint unsigned s;
      int unsigned     d;
      int unsigned     yr;
      case ($urandom_range(3))
         0: s = $urandom_range(31'h7fffffff);
         1: begin
            yr = $urandom_range(2038, 1971);
            d  = 0;
            for (int unsigned y = FIRST_CAL_YEAR; y < yr; y++) d += year_length(y);
            d = d - $urandom_range(1);
            s = longint'(d) * DAY_SECS + ($urandom_range(1) ? 0 : DAY_SECS - 1);
         end
         default: begin
            d = $urandom_range(LAST_DAY);
            case ($urandom_range(2))
               0:       s = longint'(d) * DAY_SECS;
               1:       s = longint'(d) * DAY_SECS + DAY_SECS - 1;
               default: s = longint'(d) * DAY_SECS + $urandom_range(DAY_SECS - 1);
            endcase
         end
      endcase
      if (s > SECS_MAX) s = $urandom_range(31'h7fffffff);
      return s[30:0];
   endfunction

   task automatic run_random(input int count, input int idle_pct, input int stall_p);
      send_idle_pct = idle_pct;
      stall_pct     = stall_p;
      repeat (count) send_item(pick_seconds());
      drain();
   endtask

   logic [30:0] directed[] = '{
      31'd0, SECS_MAX, 31'd59, 31'd60, 31'd3599, 31'd86399, 31'd86400,
      31'd31535999, 31'd31536000,
      31'd68255999, 31'd68256000,
      31'd94521600, 31'd94607999, 31'd94608000,
      31'd946684799, 31'd946684800, 31'd951782400,
      31'd978220800, 31'd978307199, 31'd978307200,
      31'd1073741824, 31'h2aaaaaaa, 31'h55555555,
      31'd2145916799, 31'd2145916800
   };

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_item(directed[i]);
      run_random(250, 0, 0);

      // output held off while input keeps offering
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      @(negedge clock);
      send_idle_pct = 0;
      repeat (40) send_item(pick_seconds());
      drain();

      run_random(250, 86, 0);
      run_random(250, 0, 86);
      run_random(300, 34, 34);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (dates.errors == 0 && dates.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
